FILE: src/dsu_pkg.sv
// Shared types and constants for the disjoint-set union engine.
// Used by dsu_ctrl, dsu_datapath and disjoint_set_union_engine_core.
package dsu_pkg;

    localparam int MODE_W = 2;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;
    localparam int RANK_W = 4;

    localparam logic [MODE_W-1:0] MODE_UNION = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIND  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [RANK_W-1:0] RANK_LIMIT = 4'd15;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_START,
        S_CHASE,
        S_COMPRESS,
        S_LINK,
        S_DONE
    } t_dsu_state;

    // Which root search of an item is running.
    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_FINAL
    } t_dsu_phase;

    typedef struct packed {
        logic       in_ready;
        logic       accept;
        logic       sweep_start;
        logic       sweep_en;
        logic       chase_start;
        logic       chase_step;
        logic       compress_step;
        logic       link;
        logic       load_out;
        t_dsu_phase phase;
    } t_dsu_cmd;

    typedef struct packed {
        logic in_err;
        logic sweep_last;
        logic found;
        logic path_done;
    } t_dsu_status;

    typedef struct packed {
        logic [IDX_W-1:0] first_root;
        logic [IDX_W-1:0] second_root;
        logic             merged;
        logic [CNT_W-1:0] set_count;
        logic             index_error;
    } t_dsu_result;

endpackage

FILE: src/disjoint_set_union_engine_core.sv
// Top level of the disjoint-set union engine; uses dsu_pkg, dsu_ctrl, dsu_datapath.
// A find runs one root search (a chase to the root, then path compression); a union
// runs three root searches plus a link.
// Throughput: one item at a time, one parent hop per cycle; input reopens in the cycle after the result is loaded.
// Reset (synchronous, active low) starts an identity sweep over all MAX_ELEMENTS entries
// with no item taken; an element_count write or a clear item runs the same sweep.
module disjoint_set_union_engine_core import dsu_pkg::*; #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [IDX_W-1:0]  i_first_index,
    input  logic [IDX_W-1:0]  i_second_index,

    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [IDX_W-1:0]  o_first_root,
    output logic [IDX_W-1:0]  o_second_root,
    output logic              o_merged,
    output logic [CNT_W-1:0]  o_set_count,
    output logic              o_index_error,

    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CNT_W-1:0]  i_element_count
);

    // The element count is clamped to 1..ACT_CAP (MAX_ELEMENTS, but at most 2047) when
    // it is written, so the datapath only ever sees a usable count.
    localparam int ACT_CAP   = (MAX_ELEMENTS > 2047) ? 2047 : MAX_ELEMENTS;
    localparam int ACT_RESET = (MAX_ELEMENTS > 1024) ? 1024 : MAX_ELEMENTS;

    logic [CNT_W-1:0] r_active_count, n_active_count;
    logic             r_out_valid, n_out_valid;
    t_dsu_result      r_out, n_out;

    t_dsu_cmd         cmd;
    t_dsu_status      status;
    t_dsu_result      result;
    logic             cfg_write;
    logic             out_free;

    // The register port is always open; a write restarts the identity sweep.
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid;

    // The output register can take a new result when it is empty or being drained
    // this cycle; while it holds a stalled result, a finished item waits in S_DONE to be loaded.
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_active_count = r_active_count;
        if (cfg_write) begin
            if (i_element_count == '0) begin
                n_active_count = CNT_W'(1);
            end else if (i_element_count > CNT_W'(ACT_CAP)) begin
                n_active_count = CNT_W'(ACT_CAP);
            end else begin
                n_active_count = i_element_count;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
            n_out       = result;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_count <= CNT_W'(ACT_RESET);
            r_out_valid    <= 1'b0;
        end else begin
            r_active_count <= n_active_count;
            r_out_valid    <= n_out_valid;
        end
    end

    // The result payload only changes when a new result is loaded.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    dsu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .i_cfg_write (cfg_write),
        .i_out_free  (out_free),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    dsu_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_mode         (i_mode),
        .i_first_index  (i_first_index),
        .i_second_index (i_second_index),
        .i_active_count (r_active_count),
        .o_status       (status),
        .o_result       (result)
    );

    // The input side is open only while the controller waits for an item.
    assign o_in_stall    = !cmd.in_ready;

    assign o_out_valid   = r_out_valid;
    assign o_first_root  = r_out.first_root;
    assign o_second_root = r_out.second_root;
    assign o_merged      = r_out.merged;
    assign o_set_count   = r_out.set_count;
    assign o_index_error = r_out.index_error;

`ifndef NO_ASSERTIONS
    // Once an item is taken the engine is busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("item accepted while the previous one was still starting");

    // A result only appears after the controller has asked for it to be loaded.
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.load_out))
        else $error("result valid without a load command");

    // A rejected index leaves roots and merge flag at zero.
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_index_error) |->
            ((o_first_root == '0) && (o_second_root == '0) && !o_merged))
        else $error("index error result carries root or merge data");
`endif

endmodule

FILE: src/dsu_ctrl.sv
// Controller state machine of the disjoint-set union engine.
// Depends on dsu_pkg; drives the datapath through t_dsu_cmd.
module dsu_ctrl import dsu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [MODE_W-1:0] i_mode,
    input  logic              i_cfg_write,
    input  logic              i_out_free,
    input  t_dsu_status       i_status,
    output t_dsu_cmd          o_cmd
);

    t_dsu_state r_state, n_state;
    t_dsu_phase r_phase, n_phase;
    logic       r_union, n_union;
    logic       r_reply, n_reply;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_union = r_union;
        n_reply = r_reply;
        if (i_cfg_write) begin
            n_state = S_SWEEP;
            n_reply = 1'b0;
        end else begin
            case (r_state)
                S_SWEEP: begin
                    if (i_status.sweep_last) begin
                        n_state = r_reply ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        n_union = (i_mode == MODE_UNION);
                        n_phase = PH_FIRST;
                        case (i_mode)
                            MODE_UNION, MODE_FIND: begin
                                n_state = i_status.in_err ? S_DONE : S_START;
                            end
                            MODE_CLEAR: begin
                                n_state = S_SWEEP;
                                n_reply = 1'b1;
                            end
                            default: begin
                                n_state = S_DONE;
                            end
                        endcase
                    end
                end
                S_START: begin
                    n_state = S_CHASE;
                end
                S_CHASE: begin
                    if (i_status.found) begin
                        n_state = S_COMPRESS;
                    end
                end
                S_COMPRESS: begin
                    if (i_status.path_done) begin
                        case (r_phase)
                            PH_FIRST: begin
                                if (r_union) begin
                                    n_phase = PH_SECOND;
                                    n_state = S_START;
                                end else begin
                                    n_state = S_DONE;
                                end
                            end
                            PH_SECOND: begin
                                n_state = S_LINK;
                            end
                            default: begin
                                n_state = S_DONE;
                            end
                        endcase
                    end
                end
                S_LINK: begin
                    n_phase = PH_FINAL;
                    n_state = S_START;
                end
                S_DONE: begin
                    if (i_out_free) begin
                        n_state = S_IDLE;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.phase       = r_phase;
        o_cmd.sweep_start = i_cfg_write;
        case (r_state)
            S_SWEEP: begin
                o_cmd.sweep_en = !i_cfg_write;
            end
            S_IDLE: begin
                o_cmd.in_ready = !i_cfg_write;
                o_cmd.accept   = i_in_valid && !i_cfg_write;
                if (i_in_valid && !i_cfg_write && (i_mode == MODE_CLEAR)) begin
                    o_cmd.sweep_start = 1'b1;
                end
            end
            S_START: begin
                o_cmd.chase_start = 1'b1;
            end
            S_CHASE: begin
                o_cmd.chase_step = 1'b1;
            end
            S_COMPRESS: begin
                o_cmd.compress_step = 1'b1;
            end
            S_LINK: begin
                o_cmd.link = 1'b1;
            end
            S_DONE: begin
                o_cmd.load_out = i_out_free;
            end
            default: begin
                o_cmd.in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_phase <= PH_FIRST;
            r_union <= 1'b0;
            r_reply <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_union <= n_union;
            r_reply <= n_reply;
        end
    end

endmodule

FILE: src/dsu_datapath.sv
// Datapath of the disjoint-set union engine: parent and rank memories,
// root search pointer, item registers and the live set counter. Depends on dsu_pkg.
module dsu_datapath import dsu_pkg::*; #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dsu_cmd          i_cmd,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [IDX_W-1:0]  i_first_index,
    input  logic [IDX_W-1:0]  i_second_index,
    input  logic [CNT_W-1:0]  i_active_count,
    output t_dsu_status       o_status,
    output t_dsu_result       o_result
);

    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam logic [IW-1:0] LAST_ENTRY = IW'(MAX_ELEMENTS - 1);

    logic [IW-1:0]     r_parent_mem [MAX_ELEMENTS];
    logic [RANK_W-1:0] r_rank_mem   [MAX_ELEMENTS];

    logic [IW-1:0]     r_rd_parent;
    logic [RANK_W-1:0] r_rd_rank;

    logic [IW-1:0]     r_cur, n_cur;
    logic [IW-1:0]     r_start, n_start;
    logic [IW-1:0]     r_root, n_root;
    logic [IW-1:0]     r_first, n_first;
    logic [IW-1:0]     r_second, n_second;
    logic [IW-1:0]     r_root_a, n_root_a;
    logic [IW-1:0]     r_root_b, n_root_b;
    logic [RANK_W-1:0] r_rank_a, n_rank_a;
    logic [RANK_W-1:0] r_rank_b, n_rank_b;
    logic              r_merged, n_merged;
    logic              r_err, n_err;
    logic [CNT_W-1:0]  r_live, n_live;
    logic [IW-1:0]     r_sweep, n_sweep;

    logic [IW-1:0]     rd_addr;
    logic              pw_en;
    logic [IW-1:0]     pw_addr;
    logic [IW-1:0]     pw_data;
    logic              kw_en;
    logic [IW-1:0]     kw_addr;
    logic [RANK_W-1:0] kw_data;

    logic              first_bad;
    logic              second_bad;
    logic              in_err;
    logic [IW-1:0]     chase_src;

    assign first_bad  = {1'b0, i_first_index}  >= i_active_count;
    assign second_bad = {1'b0, i_second_index} >= i_active_count;
    assign in_err     = ((i_mode == MODE_UNION) && (first_bad || second_bad))
                     || ((i_mode == MODE_FIND) && first_bad);
    assign chase_src  = (i_cmd.phase == PH_SECOND) ? r_second : r_first;

    assign o_status.in_err     = in_err;
    assign o_status.sweep_last = (r_sweep == LAST_ENTRY);
    assign o_status.found      = (r_rd_parent == r_cur);
    assign o_status.path_done  = (r_cur == r_root);

    always_comb begin
        n_cur    = r_cur;
        n_start  = r_start;
        n_root   = r_root;
        n_first  = r_first;
        n_second = r_second;
        n_root_a = r_root_a;
        n_root_b = r_root_b;
        n_rank_a = r_rank_a;
        n_rank_b = r_rank_b;
        n_merged = r_merged;
        n_err    = r_err;
        n_live   = r_live;
        n_sweep  = r_sweep;
        rd_addr  = r_cur;
        pw_en    = 1'b0;
        pw_addr  = r_cur;
        pw_data  = r_root;
        kw_en    = 1'b0;
        kw_addr  = r_root_b;
        kw_data  = r_rank_b + RANK_W'(1);

        if (i_cmd.accept) begin
            n_first  = IW'(i_first_index);
            n_second = IW'(i_second_index);
            n_err    = in_err;
            n_root_a = '0;
            n_root_b = '0;
            n_merged = 1'b0;
        end

        // Identity sweep: one entry per cycle, live count restored at the end.
        if (i_cmd.sweep_en) begin
            pw_en   = 1'b1;
            pw_addr = r_sweep;
            pw_data = r_sweep;
            kw_en   = 1'b1;
            kw_addr = r_sweep;
            kw_data = '0;
            n_sweep = r_sweep + IW'(1);
            if (r_sweep == LAST_ENTRY) begin
                n_live = i_active_count;
            end
        end
        if (i_cmd.sweep_start) begin
            n_sweep = '0;
        end

        if (i_cmd.chase_start) begin
            rd_addr = chase_src;
            n_cur   = chase_src;
            n_start = chase_src;
        end

        // One parent hop per cycle; the read data belongs to r_cur.
        if (i_cmd.chase_step) begin
            if (r_rd_parent == r_cur) begin
                n_root = r_cur;
                if (i_cmd.phase == PH_SECOND) begin
                    n_root_b = r_cur;
                    n_rank_b = r_rd_rank;
                end else begin
                    n_root_a = r_cur;
                    n_rank_a = r_rd_rank;
                end
                rd_addr = r_start;
                n_cur   = r_start;
            end else begin
                rd_addr = r_rd_parent;
                n_cur   = r_rd_parent;
            end
        end

        // Second walk: point every node on the path straight at the root.
        if (i_cmd.compress_step && (r_cur != r_root)) begin
            pw_en   = 1'b1;
            pw_addr = r_cur;
            pw_data = r_root;
            rd_addr = r_rd_parent;
            n_cur   = r_rd_parent;
        end

        if (i_cmd.link && (r_root_a != r_root_b)) begin
            n_merged = 1'b1;
            if (r_live != '0) begin
                n_live = r_live - CNT_W'(1);
            end
            pw_en = 1'b1;
            if (r_rank_a > r_rank_b) begin
                pw_addr = r_root_b;
                pw_data = r_root_a;
            end else begin
                pw_addr = r_root_a;
                pw_data = r_root_b;
                kw_addr = r_root_b;
                kw_data = r_rank_b + RANK_W'(1);
                kw_en   = (r_rank_a == r_rank_b) && (r_rank_b != RANK_LIMIT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pw_en) begin
            r_parent_mem[pw_addr] <= pw_data;
        end
        r_rd_parent <= r_parent_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (kw_en) begin
            r_rank_mem[kw_addr] <= kw_data;
        end
        r_rd_rank <= r_rank_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else begin
            r_sweep <= n_sweep;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_start  <= n_start;
        r_root   <= n_root;
        r_first  <= n_first;
        r_second <= n_second;
        r_root_a <= n_root_a;
        r_root_b <= n_root_b;
        r_rank_a <= n_rank_a;
        r_rank_b <= n_rank_b;
        r_merged <= n_merged;
        r_err    <= n_err;
        r_live   <= n_live;
    end

    assign o_result.first_root  = IDX_W'(r_root_a);
    assign o_result.second_root = IDX_W'(r_root_b);
    assign o_result.merged      = r_merged;
    assign o_result.set_count   = r_live;
    assign o_result.index_error = r_err;

endmodule
